/* rtl/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg: shared types, constants and melody ROM of the buzzer sequencer
// Phase codes, register defaults, note tables and the ROM lookup functions.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Sizing of the note ROM
  localparam int NOTE_ROM_DEPTH = 16;
  localparam int ROM_USED       = 12;

  localparam int IDX_W  = 4;   // note index kept in state
  localparam int ADDR_W = 5;   // lookup address, holds index + 1
  localparam int MS_W   = 10;
  localparam int CNT_W  = 10;
  localparam int PER_W  = 10;
  localparam int REQ_W  = 4;

  // Register defaults
  localparam logic [MS_W-1:0]  GAP_MS_RST       = 10'd180;
  localparam logic [CNT_W-1:0] TICKS_PER_MS_RST = 10'd1000;

  // Request / sound bits
  localparam logic [REQ_W-1:0] REQ_POWER_ON = 4'b0001;

  // Configuration register map (word index)
  localparam logic CFG_GAP_MS       = 1'b0;
  localparam logic CFG_TICKS_PER_MS = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [REQ_W-1:0] batch;
    logic [1:0]       cur;
    logic [IDX_W-1:0] idx;
    logic [MS_W-1:0]  ms;
  } play_t;

  // Tone frequencies in Hz and the derived half-cycle-free periods in ticks
  localparam int TICKS_PER_S = 1000000;
  localparam int PER_MIN     = 2;
  localparam int FREQ_C6     = 1047;
  localparam int FREQ_C7     = 2093;
  localparam int FREQ_E7     = 2637;
  localparam int FREQ_F7     = 2794;
  localparam int FREQ_A7     = 3520;

  function automatic logic [PER_W-1:0] clamp_period(input int p);
    return PER_W'((p < PER_MIN) ? PER_MIN : p);
  endfunction

  localparam logic [PER_W-1:0] PER_C6 = clamp_period(TICKS_PER_S / FREQ_C6);
  localparam logic [PER_W-1:0] PER_C7 = clamp_period(TICKS_PER_S / FREQ_C7);
  localparam logic [PER_W-1:0] PER_E7 = clamp_period(TICKS_PER_S / FREQ_E7);
  localparam logic [PER_W-1:0] PER_F7 = clamp_period(TICKS_PER_S / FREQ_F7);
  localparam logic [PER_W-1:0] PER_A7 = clamp_period(TICKS_PER_S / FREQ_A7);

  function automatic logic rom_hit(input logic [ADDR_W-1:0] addr);
    return (int'(addr) < ROM_USED) && (int'(addr) < NOTE_ROM_DEPTH);
  endfunction

  // Duration in ms; zero marks the end of a melody
  function automatic logic [MS_W-1:0] rom_dur(input logic [ADDR_W-1:0] addr);
    logic [MS_W-1:0] d;
    unique case (addr)
      5'd0, 5'd2:               d = 10'd90;
      5'd1, 5'd3:               d = 10'd60;
      5'd4:                     d = 10'd170;
      5'd6, 5'd8, 5'd10:        d = 10'd120;
      default:                  d = '0;
    endcase
    return rom_hit(addr) ? d : '0;
  endfunction

  // Note period in ticks; zero for a rest
  function automatic logic [PER_W-1:0] rom_period(input logic [ADDR_W-1:0] addr);
    logic [PER_W-1:0] p;
    unique case (addr)
      5'd0:         p = PER_C7;
      5'd2:         p = PER_F7;
      5'd4, 5'd10:  p = PER_A7;
      5'd6:         p = PER_E7;
      5'd8:         p = PER_C6;
      default:      p = '0;
    endcase
    return rom_hit(addr) ? p : '0;
  endfunction

  function automatic logic [IDX_W-1:0] melody_start(input logic [1:0] s);
    logic [IDX_W-1:0] a;
    unique case (s)
      2'd0:    a = 4'd0;
      2'd1:    a = 4'd6;
      2'd2:    a = 4'd8;
      default: a = 4'd10;
    endcase
    return a;
  endfunction

  // Sounds whose melody is empty (end marker at the start address)
  localparam logic [REQ_W-1:0] EMPTY_MASK = {
    rom_dur({1'b0, melody_start(2'd3)}) == '0,
    rom_dur({1'b0, melody_start(2'd2)}) == '0,
    rom_dur({1'b0, melody_start(2'd1)}) == '0,
    rom_dur({1'b0, melody_start(2'd0)}) == '0
  };

endpackage

/* rtl/bms_in_if.sv */
// ----------------------------------------------------------------------------
// bms_in_if: input channel of the buzzer sequencer
// One timer tick and the sound request bits per transfer.
// ----------------------------------------------------------------------------
interface bms_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] request;
  logic       tick;

  modport source (output valid, output request, output tick, input ready);
  modport sink   (input valid, input request, input tick, output ready);
endinterface

/* rtl/bms_out_if.sv */
// ----------------------------------------------------------------------------
// bms_out_if: result channel of the buzzer sequencer
// Buzzer drive level and play status per transfer.
// ----------------------------------------------------------------------------
interface bms_out_if;
  logic       valid;
  logic       ready;
  logic       wave_level;
  logic       tone_active;
  logic       busy_res;
  logic [9:0] note_period;

  modport source (output valid, output wave_level, output tone_active,
                  output busy_res, output note_period, input ready);
  modport sink   (input valid, input wave_level, input tone_active,
                  input busy_res, input note_period, output ready);
endinterface

/* rtl/buzzer_melody_sequencer_top.sv */
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer_top: ROM melody player for a passive buzzer
// Collects sound requests, plays each batch in fixed order as square waves.
// ----------------------------------------------------------------------------
// Every input transfer (one timer tick plus request bits) yields one result
// transfer, which appears from the output register in the next cycle; a new
// transfer is taken every cycle as long as that register is empty or being
// read in the same cycle, so the block runs at one tick per clock. The result
// shows the state after the tick: the 50% duty square wave, whether a note
// sounds, whether a melody or its trailing gap is running, and the current
// note period. Requests are ORed into a pending set (power-on is pending out
// of reset); when idle the pending set is latched and played power-on,
// activation, left, right. gap_ms (byte address 0) and ticks_per_ms (byte
// address 4) are to be written through the APB port by the user only while
// idle; the block itself does not enforce this. A running gap keeps its length.
module buzzer_melody_sequencer_top
  import bms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bms_in_if.sink      in_if,
  bms_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration
  logic [MS_W-1:0]  gap_ms_r;
  logic [CNT_W-1:0] tpm_r;
  logic             cfg_wr;

  // Play state
  play_t             play_r, play_nxt, play_tick, after_note;
  logic [REQ_W-1:0]  pending_r, pending_nxt, pend_or;
  logic [CNT_W-1:0]  sub_r, sub_nxt;
  logic [CNT_W-1:0]  wave_r, wave_nxt;

  // Result register
  logic              out_valid_r;
  logic              wave_level_r, tone_active_r, busy_res_r;
  logic [PER_W-1:0]  note_period_r;

  logic              accept;
  logic [PER_W-1:0]  period_cur, period_out;
  logic [CNT_W:0]    wave_inc, sub_inc;
  logic              ms_event;
  logic [MS_W-1:0]   ms_dec;
  logic [ADDR_W-1:0] next_addr;
  logic [MS_W-1:0]   next_dur;
  logic [REQ_W-1:0]  rest_set;

  function automatic logic [1:0] lowest_bit(input logic [REQ_W-1:0] set);
    logic [1:0] s;
    s = 2'd0;
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if (set[i]) s = 2'(i);
    end
    return s;
  endfunction

  // Start the first playable sound of a set; with no gap, empty melodies
  // are skipped entirely.
  function automatic play_t launch(input logic [REQ_W-1:0] set,
                                   input logic [MS_W-1:0]  gap,
                                   input play_t            prev);
    play_t            p;
    logic [REQ_W-1:0] eff;
    logic [1:0]       s;
    p   = prev;
    eff = (gap == '0) ? (set & ~EMPTY_MASK) : set;
    s   = lowest_bit(eff);
    if (eff == '0) begin
      p.phase = PH_IDLE;
      p.batch = '0;
      p.ms    = '0;
    end else begin
      p.cur   = s;
      p.batch = set & ~((REQ_W'(1) << s) - REQ_W'(1));
      if (EMPTY_MASK[s]) begin
        p.phase = PH_GAP;
        p.ms    = gap;
      end else begin
        p.phase = PH_NOTE;
        p.idx   = melody_start(s);
        p.ms    = rom_dur({1'b0, melody_start(s)});
      end
    end
    return p;
  endfunction

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_TICKS_PER_MS) ? {22'b0, tpm_r} : {22'b0, gap_ms_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ms_r <= GAP_MS_RST;
      tpm_r    <= TICKS_PER_MS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_GAP_MS) gap_ms_r <= pwdata[MS_W-1:0];
      else                        tpm_r    <= pwdata[CNT_W-1:0];
    end
  end

  // Time base
  assign pend_or    = pending_r | in_if.request;
  assign period_cur = (play_r.phase == PH_NOTE) ? rom_period({1'b0, play_r.idx}) : '0;
  assign wave_inc   = {1'b0, wave_r} + 1'b1;
  assign sub_inc    = {1'b0, sub_r} + 1'b1;
  assign ms_event   = in_if.tick && (play_r.phase != PH_IDLE) &&
                      (sub_inc >= {1'b0, tpm_r});
  assign ms_dec     = (play_r.ms != '0) ? play_r.ms - 1'b1 : '0;
  assign next_addr  = {1'b0, play_r.idx} + 1'b1;
  assign next_dur   = rom_dur(next_addr);
  assign rest_set   = play_r.batch & ~(REQ_W'(1) << play_r.cur);

  // Segment end: next note, gap, or the next sound of the batch
  always_comb begin
    after_note = play_r;
    if (play_r.phase == PH_NOTE && next_dur != '0) begin
      after_note.idx = next_addr[IDX_W-1:0];
      after_note.ms  = next_dur;
    end else if (play_r.phase == PH_NOTE && gap_ms_r != '0) begin
      after_note.phase = PH_GAP;
      after_note.ms    = gap_ms_r;
    end else begin
      after_note = launch(rest_set, gap_ms_r, play_r);
    end
  end

  always_comb begin
    play_tick = play_r;
    wave_nxt  = wave_r;
    sub_nxt   = sub_r;
    if (in_if.tick && play_r.phase != PH_IDLE) begin
      if (period_cur != '0) begin
        wave_nxt = (wave_inc >= {1'b0, period_cur}) ? '0 : wave_inc[CNT_W-1:0];
      end
      sub_nxt = sub_inc[CNT_W-1:0];
      if (ms_event) begin
        sub_nxt      = '0;
        play_tick.ms = ms_dec;
        if (ms_dec == '0) begin
          play_tick = after_note;
          wave_nxt  = '0;
        end
      end
    end

    // Latch a new batch once idle
    play_nxt    = play_tick;
    pending_nxt = pend_or;
    if (play_tick.phase == PH_IDLE && pend_or != '0) begin
      play_nxt    = launch(pend_or, gap_ms_r, play_tick);
      pending_nxt = '0;
      wave_nxt    = '0;
      sub_nxt     = '0;
    end
  end

  assign period_out = (play_nxt.phase == PH_NOTE) ? rom_period({1'b0, play_nxt.idx}) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r      <= '{phase: PH_IDLE, batch: '0, cur: '0, idx: '0, ms: '0};
      pending_r   <= REQ_POWER_ON;
      sub_r       <= '0;
      wave_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        play_r    <= play_nxt;
        pending_r <= pending_nxt;
        sub_r     <= sub_nxt;
        wave_r    <= wave_nxt;
      end
      if (accept)             out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wave_level_r  <= (period_out != '0) && (wave_nxt < {1'b0, period_out[PER_W-1:1]});
      tone_active_r <= (period_out != '0);
      busy_res_r    <= (play_nxt.phase != PH_IDLE);
      note_period_r <= period_out;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.wave_level  = wave_level_r;
  assign out_if.tone_active = tone_active_r;
  assign out_if.busy_res    = busy_res_r;
  assign out_if.note_period = note_period_r;

`ifndef NO_ASSERTIONS
  a_note_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    play_r.phase == PH_NOTE |-> play_r.ms != '0)
    else $error("note running with no time left");

  a_idle_no_batch: assert property (@(posedge clk) disable iff (!rst_n)
    play_r.phase == PH_IDLE |-> play_r.batch == '0)
    else $error("idle with sounds left in batch");

  a_cur_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    play_r.phase != PH_IDLE |-> play_r.batch[play_r.cur])
    else $error("current sound not in batch");

  a_tone_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && tone_active_r |-> busy_res_r && note_period_r >= 10'd2)
    else $error("tone without busy or with short period");
`endif

endmodule

/* tb/sv/tb_buzzer_melody_sequencer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buzzer_melody_sequencer_top: self-checking bench for the melody sequencer
// Streams tick/request transfers under random stalls on both channels, keeps
// a cycle-true model of the melody player and compares every result transfer.
// Configuration moves through fast, zero and extreme gap and tick settings.
// ----------------------------------------------------------------------------
module tb_buzzer_melody_sequencer_top;
  import bms_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 11;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_BUDGET = 1300;
  localparam int HOLD_CYCLES = 400;

  localparam logic [REQ_W-1:0] REQ_ACTIVATION = 4'b0010;
  localparam logic [REQ_W-1:0] REQ_LEFT       = 4'b0100;
  localparam logic [REQ_W-1:0] REQ_RIGHT      = 4'b1000;
  localparam logic [REQ_W-1:0] REQ_ALL        = 4'b1111;
  localparam logic [REQ_W-1:0] REQ_NONE       = 4'b0000;

  typedef struct packed {
    logic [REQ_W-1:0] request;
    logic             tick;
  } tick_item_t;

  typedef struct packed {
    logic             wave_level;
    logic             tone_active;
    logic             busy_res;
    logic [PER_W-1:0] note_period;
  } tone_obs_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bms_in_if  in_ch();
  bms_out_if out_ch();

  buzzer_melody_sequencer_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_item_t pending_ticks[$];
  tone_obs_t  expected_tones[$];

  int  fail_cnt;
  int  cyc_cnt;
  int  tx_cyc;
  int  rx_cyc;
  int  sent_cnt;
  int  hold_left;
  bit  hold_done;
  bit  rx_hold_ask;
  bit  in_fire;

  // Player model state and its copy of the registers
  logic [MS_W-1:0]  gap_reg;
  logic [CNT_W-1:0] tpm_reg;
  logic [REQ_W-1:0] snd_pending;
  logic [REQ_W-1:0] snd_batch;
  phase_t           play_ph;
  logic [1:0]       snd_cur;
  logic [IDX_W-1:0] rom_addr;
  logic [MS_W-1:0]  ms_remain;
  logic [CNT_W-1:0] tick_in_ms;
  logic [CNT_W-1:0] wave_pos;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Melody table: duration in ms, zero ends a melody
  function automatic int unsigned note_ms(input int unsigned addr);
    int unsigned d;
    d = 0;
    if (addr < NOTE_ROM_DEPTH) begin
      case (addr)
        0, 2:     d = 90;
        1, 3:     d = 60;
        4:        d = 170;
        6, 8, 10: d = 120;
        default:  d = 0;
      endcase
    end
    return d;
  endfunction

  // Note period in ticks, zero for rests
  function automatic logic [PER_W-1:0] note_ticks(input int unsigned addr);
    int unsigned hz;
    int unsigned p;
    hz = 0;
    if (addr < NOTE_ROM_DEPTH) begin
      case (addr)
        0:       hz = 2093;
        2:       hz = 2794;
        4, 10:   hz = 3520;
        6:       hz = 2637;
        8:       hz = 1047;
        default: hz = 0;
      endcase
    end
    if (hz == 0) return '0;
    p = 1000000 / hz;
    if (p < 2) p = 2;
    return p[PER_W-1:0];
  endfunction

  function automatic int unsigned sound_start(input logic [1:0] s);
    case (s)
      2'd0:    return 0;
      2'd1:    return 6;
      2'd2:    return 8;
      default: return 10;
    endcase
  endfunction

  function automatic logic [1:0] first_sound(input logic [REQ_W-1:0] set);
    for (int i = 0; i < REQ_W; i++)
      if (set[i]) return 2'(i);
    return 2'd0;
  endfunction

  function automatic logic [PER_W-1:0] live_period();
    return (play_ph == PH_NOTE) ? note_ticks(rom_addr) : '0;
  endfunction

  // Stage 0 tries a note at addr, 1 opens the gap, 2 moves to the next sound
  task automatic advance_play(input int unsigned start_addr, input int start_stage);
    int unsigned addr;
    int unsigned d;
    int          stage;
    int          guard;
    bit          done;
    addr  = start_addr;
    stage = start_stage;
    done  = 1'b0;
    for (guard = 0; guard < 32 && !done; guard++) begin
      if (stage == 0) begin
        d = note_ms(addr);
        if (d != 0) begin
          play_ph    = PH_NOTE;
          rom_addr   = addr[IDX_W-1:0];
          ms_remain  = d[MS_W-1:0];
          tick_in_ms = '0;
          wave_pos   = '0;
          done       = 1'b1;
        end else begin
          stage = 1;
        end
      end else if (stage == 1) begin
        play_ph    = PH_GAP;
        ms_remain  = gap_reg;
        tick_in_ms = '0;
        wave_pos   = '0;
        if (ms_remain != 0) done = 1'b1;
        else stage = 2;
      end else begin
        snd_batch = snd_batch & ~(REQ_W'(1) << snd_cur);
        if (snd_batch == '0) begin
          play_ph    = PH_IDLE;
          ms_remain  = '0;
          tick_in_ms = '0;
          wave_pos   = '0;
          done       = 1'b1;
        end else begin
          snd_cur = first_sound(snd_batch);
          addr    = sound_start(snd_cur);
          stage   = 0;
        end
      end
    end
    if (!done) play_ph = PH_IDLE;
  endtask

  task automatic buzzer_step(input tick_item_t it, output tone_obs_t res);
    int unsigned p;
    int unsigned cnt;
    snd_pending = snd_pending | it.request;
    if (it.tick && play_ph != PH_IDLE) begin
      p = live_period();
      if (p != 0) begin
        cnt = wave_pos + 1;
        wave_pos = (cnt >= p) ? '0 : cnt[CNT_W-1:0];
      end
      cnt = tick_in_ms + 1;
      if (cnt >= tpm_reg) begin
        tick_in_ms = '0;
        if (ms_remain != 0) ms_remain = ms_remain - 1'b1;
        if (ms_remain == 0) begin
          if (play_ph == PH_NOTE) advance_play(int'(rom_addr) + 1, 0);
          else advance_play(0, 2);
        end
      end else begin
        tick_in_ms = cnt[CNT_W-1:0];
      end
    end
    if (play_ph == PH_IDLE && snd_pending != '0) begin
      snd_batch   = snd_pending;
      snd_pending = '0;
      snd_cur     = first_sound(snd_batch);
      advance_play(sound_start(snd_cur), 0);
    end
    p = live_period();
    res.wave_level  = (p != 0) && (wave_pos < (p >> 1));
    res.tone_active = (p != 0);
    res.busy_res    = (play_ph != PH_IDLE);
    res.note_period = p[PER_W-1:0];
  endtask

  // Input side: transfer offered at the falling edge, held until taken
  always @(negedge clk) begin : drive_proc
    tick_item_t nxt;
    bit         steady;
    tx_cyc++;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      steady = (tx_cyc % 3000) < 500;
      if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
        nxt = pending_ticks.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.request <= nxt.request;
        in_ch.tick    <= nxt.tick;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : accept_proc
    tick_item_t it;
    tone_obs_t  res;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.request = in_ch.request;
      it.tick    = in_ch.tick;
      buzzer_step(it, res);
      expected_tones.push_back(res);
    end
  end

  // Result side: random stalls plus one long hold-off to back up the input
  always @(negedge clk) begin : sink_proc
    bit steady;
    rx_cyc++;
    steady = (rx_cyc % 3000) >= 1500 && (rx_cyc % 3000) < 2000;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_ask && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin : check_proc
    tone_obs_t exp_t;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tones.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_cnt++;
      end else begin
        exp_t = expected_tones.pop_front();
        if (out_ch.wave_level !== exp_t.wave_level) begin
          $error("wave_level: expected %0d, actual %0d", exp_t.wave_level, out_ch.wave_level);
          fail_cnt++;
        end
        if (out_ch.tone_active !== exp_t.tone_active) begin
          $error("tone_active: expected %0d, actual %0d",
                 exp_t.tone_active, out_ch.tone_active);
          fail_cnt++;
        end
        if (out_ch.busy_res !== exp_t.busy_res) begin
          $error("busy_res: expected %0d, actual %0d", exp_t.busy_res, out_ch.busy_res);
          fail_cnt++;
        end
        if (out_ch.note_period !== exp_t.note_period) begin
          $error("note_period: expected %0d, actual %0d",
                 exp_t.note_period, out_ch.note_period);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_tick(input logic [REQ_W-1:0] req, input logic tk);
    tick_item_t it;
    it.request = req;
    it.tick    = tk;
    pending_ticks.push_back(it);
    sent_cnt++;
  endtask

  task automatic drain_all();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_tones.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_check(input logic reg_sel, input logic [9:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {22'd0, want}) begin
      $error("%s readback: expected %0d, actual %0d",
             (reg_sel == CFG_GAP_MS) ? "gap_ms" : "ticks_per_ms", want, prdata);
      fail_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [9:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {22'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == CFG_GAP_MS) gap_reg = val;
    else tpm_reg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_check(reg_sel, val);
  endtask

  // Feed plain ticks until the model reports the player idle or the budget is spent
  task automatic run_until_silent();
    int rounds;
    for (rounds = 0; rounds < 400 && play_ph != PH_IDLE && sent_cnt < ITEM_BUDGET;
         rounds++) begin
      for (int i = 0; i < 64; i++)
        push_tick(REQ_NONE, $urandom_range(0, 9) != 0);
      drain_all();
    end
  endtask

  function automatic logic [9:0] pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 10'($urandom_range(0, 8));
    if (r < 95) return 10'($urandom_range(9, 40));
    return 10'd1023;
  endfunction

  initial begin
    int          n;
    bit          noisy;
    logic [3:0]  req;
    logic        tk;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.request = '0;
    in_ch.tick    = 1'b0;
    out_ch.ready  = 1'b0;
    fail_cnt      = 0;
    cyc_cnt       = 0;
    tx_cyc        = 0;
    rx_cyc        = 0;
    sent_cnt      = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    rx_hold_ask   = 1'b0;
    in_fire       = 1'b0;
    gap_reg       = GAP_MS_RST;
    tpm_reg       = TICKS_PER_MS_RST;
    snd_pending   = REQ_POWER_ON;
    snd_batch     = '0;
    play_ph       = PH_IDLE;
    snd_cur       = '0;
    rom_addr      = '0;
    ms_remain     = '0;
    tick_in_ms    = '0;
    wave_pos      = '0;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_check(CFG_GAP_MS, GAP_MS_RST);
    cfg_check(CFG_TICKS_PER_MS, TICKS_PER_MS_RST);

    // Directed: fastest time base and no gap, so sounds follow at once
    cfg_write(CFG_TICKS_PER_MS, 10'd1);
    cfg_write(CFG_GAP_MS, 10'd0);
    // hold the result side off once so that the input backs up
    rx_hold_ask = 1'b1;
    push_tick(REQ_NONE, 1'b0);         // power-on batch latched without a tick
    push_tick(REQ_ACTIVATION, 1'b0);
    push_tick(REQ_ACTIVATION | REQ_RIGHT, 1'b1);
    push_tick(REQ_NONE, 1'b1);
    push_tick(REQ_NONE, 1'b1);
    push_tick(REQ_RIGHT, 1'b1);
    push_tick(REQ_NONE, 1'b0);
    for (int i = 0; i < 12; i++)
      push_tick(REQ_NONE, 1'b1);
    drain_all();
    run_until_silent();

    // Zero ticks per ms runs as one; two sounds with a short gap
    cfg_write(CFG_TICKS_PER_MS, 10'd0);
    cfg_write(CFG_GAP_MS, 10'd2);
    push_tick(REQ_LEFT, 1'b1);
    push_tick(REQ_ACTIVATION, 1'b1);
    drain_all();
    run_until_silent();

    while (sent_cnt < ITEM_BUDGET - 40) begin
      if (play_ph == PH_IDLE)
        cfg_write(CFG_TICKS_PER_MS, ($urandom_range(0, 9) < 6) ? 10'd1 :
                                    10'($urandom_range(2, 3)));
      // a gap already running keeps its length, so rewrite it mid-play too
      if (play_ph == PH_IDLE || $urandom_range(0, 1) == 1)
        cfg_write(CFG_GAP_MS, pick_gap());
      n     = $urandom_range(60, 200);
      if (n > ITEM_BUDGET - sent_cnt) n = ITEM_BUDGET - sent_cnt;
      noisy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        if (noisy) begin
          tk  = 1'($urandom_range(0, 1));
          req = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(0, 15)) : REQ_NONE;
        end else begin
          tk  = ($urandom_range(0, 9) != 0);
          req = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(1, 15)) : REQ_NONE;
        end
        push_tick(req, tk);
      end
      drain_all();
    end

    // Extremes last: the slowest time base never finishes a note here
    run_until_silent();
    cfg_write(CFG_TICKS_PER_MS, 10'd1023);
    cfg_write(CFG_GAP_MS, 10'd1023);
    push_tick(REQ_ALL, 1'b1);
    for (int i = 0; i < 19; i++)
      push_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    drain_all();

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
